@@ design/thc_pkg.sv @@
package thc_pkg;

    localparam int ACCEL_W  = 16;
    localparam int SACC_W   = 8;
    localparam int SMAG_W   = 12;
    localparam int SECT_W   = 13;
    localparam int SHAKE_W  = 9;
    localparam int STILL_W  = 8;
    localparam int MOVE_W   = 2;
    localparam int COUNT_W  = 2;
    localparam int HEAD_W   = 9;
    localparam int ACC_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [SHAKE_W-1:0] SHAKE_RESET  = SHAKE_W'(25);
    localparam logic [STILL_W-1:0] STILL_RESET  = STILL_W'(14);
    localparam logic [MOVE_W-1:0]  MOVING_RESET = MOVE_W'(1);
    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;

    // window for the face pointing down: 14..18 after scaling
    localparam logic signed [SACC_W-1:0] DOWN_MIN = SACC_W'(14);
    localparam logic signed [SACC_W-1:0] DOWN_MAX = SACC_W'(18);

    localparam logic [HEAD_W-1:0] DEG_0   = HEAD_W'(0);
    localparam logic [HEAD_W-1:0] DEG_45  = HEAD_W'(45);
    localparam logic [HEAD_W-1:0] DEG_90  = HEAD_W'(90);
    localparam logic [HEAD_W-1:0] DEG_135 = HEAD_W'(135);
    localparam logic [HEAD_W-1:0] DEG_180 = HEAD_W'(180);
    localparam logic [HEAD_W-1:0] DEG_225 = HEAD_W'(225);
    localparam logic [HEAD_W-1:0] DEG_270 = HEAD_W'(270);
    localparam logic [HEAD_W-1:0] DEG_315 = HEAD_W'(315);

    localparam logic signed [SECT_W-1:0] PX_T0 = SECT_W'(7);
    localparam logic signed [SECT_W-1:0] PX_T1 = SECT_W'(4);
    localparam logic signed [SECT_W-1:0] PX_T2 = -SECT_W'(1);
    localparam logic signed [SECT_W-1:0] PX_T3 = -SECT_W'(5);
    localparam logic signed [SECT_W-1:0] NX_T0 = SECT_W'(5);
    localparam logic signed [SECT_W-1:0] NX_T1 = SECT_W'(2);
    localparam logic signed [SECT_W-1:0] NX_T2 = -SECT_W'(4);
    localparam logic signed [SECT_W-1:0] NX_T3 = -SECT_W'(7);
    localparam logic signed [SECT_W-1:0] PY_T0 = SECT_W'(3);
    localparam logic signed [SECT_W-1:0] PY_T1 = SECT_W'(0);
    localparam logic signed [SECT_W-1:0] PY_T2 = -SECT_W'(7);
    localparam logic signed [SECT_W-1:0] PY_T3 = -SECT_W'(11);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHAKE_LIMIT = 2'd0,
        CFG_STILL_LIMIT = 2'd1,
        CFG_MOVING_MIN  = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FACE_NONE = 2'd0,
        FACE_PX   = 2'd1,
        FACE_NX   = 2'd2,
        FACE_PY   = 2'd3
    } t_face;

    typedef struct packed {
        logic signed [ACCEL_W-1:0] accel_x;
        logic signed [ACCEL_W-1:0] accel_y;
        logic signed [ACCEL_W-1:0] accel_z;
        logic signed [ACCEL_W-1:0] mag_x;
        logic signed [ACCEL_W-1:0] mag_y;
        logic signed [ACCEL_W-1:0] mag_z;
    } t_in;

    typedef struct packed {
        logic [HEAD_W-1:0] heading_deg;
        logic [ACC_W-1:0]  accuracy;
        logic              is_moving;
    } t_out;

    typedef struct packed {
        logic [SHAKE_W-1:0] shake_limit;
        logic [STILL_W-1:0] still_limit;
        logic [MOVE_W-1:0]  moving_min_rejects;
    } t_cfg;

    typedef struct packed {
        logic reject;
        t_out result;
    } t_cls;

    // truncating divide by 256
    function automatic logic signed [SACC_W-1:0] f_scale_accel(
        input logic signed [ACCEL_W-1:0] x);
        logic signed [ACCEL_W:0] t;
        t = {x[ACCEL_W-1], x} + (x[ACCEL_W-1] ? (ACCEL_W+1)'(255) : '0);
        return t[ACCEL_W-1:8];
    endfunction

    // truncating divide by 16
    function automatic logic signed [SMAG_W-1:0] f_scale_mag(
        input logic signed [ACCEL_W-1:0] x);
        logic signed [ACCEL_W:0] t;
        t = {x[ACCEL_W-1], x} + (x[ACCEL_W-1] ? (ACCEL_W+1)'(15) : '0);
        return t[ACCEL_W-1:4];
    endfunction

    function automatic logic [SACC_W-1:0] f_abs(input logic signed [SACC_W-1:0] x);
        return x[SACC_W-1] ? (~x + SACC_W'(1)) : x;
    endfunction

    function automatic logic [HEAD_W-1:0] f_sector(
        input logic signed [SECT_W-1:0] m,
        input logic signed [SECT_W-1:0] t0,
        input logic signed [SECT_W-1:0] t1,
        input logic signed [SECT_W-1:0] t2,
        input logic signed [SECT_W-1:0] t3,
        input logic                     zpos);
        logic [HEAD_W-1:0] d;
        if (m > t0) begin
            d = DEG_270;
        end else if (m > t1) begin
            d = zpos ? DEG_225 : DEG_315;
        end else if (m > t2) begin
            d = zpos ? DEG_180 : DEG_0;
        end else if (m > t3) begin
            d = zpos ? DEG_135 : DEG_45;
        end else begin
            d = DEG_90;
        end
        return d;
    endfunction

endpackage

@@ design/thc_classify.sv @@
module thc_classify (
    input  thc_pkg::t_in                     i_sample,
    input  thc_pkg::t_cfg                    i_cfg,
    input  logic [thc_pkg::COUNT_W-1:0]      i_reject_count,
    output thc_pkg::t_cls                    o_cls
);
    import thc_pkg::*;

    logic signed [SACC_W-1:0] ax, ay, az;
    logic signed [SMAG_W-1:0] mx, my, mz;
    logic [SACC_W-1:0]        abs_x, abs_y, abs_z;
    logic [SHAKE_W-1:0]       abs_sum;
    logic signed [SACC_W-1:0] down_mag;
    logic signed [SECT_W-1:0] m_my, m_mx;
    t_face                    face;
    logic                     shaking, still, zpos;
    logic [ACC_W-1:0]         acc;
    logic [HEAD_W-1:0]        dir;

    always_comb begin
        ax = f_scale_accel(i_sample.accel_x);
        ay = f_scale_accel(i_sample.accel_y);
        az = f_scale_accel(i_sample.accel_z);
        mx = f_scale_mag(i_sample.mag_x);
        my = f_scale_mag(i_sample.mag_y);
        mz = f_scale_mag(i_sample.mag_z);

        abs_x   = f_abs(ax);
        abs_y   = f_abs(ay);
        abs_z   = f_abs(az);
        abs_sum = SHAKE_W'(abs_x) + SHAKE_W'(abs_y) + SHAKE_W'(abs_z);

        shaking = abs_sum > i_cfg.shake_limit;
        still   = (abs_x < i_cfg.still_limit) && (abs_y < i_cfg.still_limit)
               && (abs_z < i_cfg.still_limit);

        if (ax >= DOWN_MIN && ax <= DOWN_MAX) begin
            face     = FACE_PX;
            down_mag = ax;
        end else if (ax <= -DOWN_MIN && ax >= -DOWN_MAX) begin
            face     = FACE_NX;
            down_mag = -ax;
        end else if (ay >= DOWN_MIN && ay <= DOWN_MAX) begin
            face     = FACE_PY;
            down_mag = ay;
        end else begin
            face     = FACE_NONE;
            down_mag = '0;
        end

        m_my = $signed({my[SMAG_W-1], my});
        m_mx = $signed({mx[SMAG_W-1], mx});
        zpos = (mz > 0);

        case (face)
            FACE_PX: dir = f_sector(-m_my, PX_T0, PX_T1, PX_T2, PX_T3, zpos);
            FACE_NX: dir = f_sector(m_my, NX_T0, NX_T1, NX_T2, NX_T3, zpos);
            FACE_PY: dir = f_sector(m_mx, PY_T0, PY_T1, PY_T2, PY_T3, zpos);
            default: dir = DEG_90;
        endcase

        case (down_mag)
            SACC_W'(16):              acc = ACC_W'(3);
            SACC_W'(15), SACC_W'(17): acc = ACC_W'(2);
            SACC_W'(14), SACC_W'(18): acc = ACC_W'(1);
            default:                  acc = '0;
        endcase

        o_cls.reject             = shaking || still || (face == FACE_NONE);
        o_cls.result.heading_deg = dir;
        o_cls.result.accuracy    = acc;
        o_cls.result.is_moving   = (MOVE_W'(i_reject_count) > i_cfg.moving_min_rejects);
    end

endmodule

@@ design/tilt_heading_classifier_core.sv @@
// Channel  Direction  Handshake                     Payload
// sample   in         i_valid / o_ready             i_data  (t_in)
// result   out        o_valid / i_ready             o_data  (t_out)
// config   in         i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// One sample per cycle, unless a stalled result register blocks an accepted sample.
// The input register feeds one pass of compare logic into the result register.
// Rejected samples give no result and only bump the reject counter.
// Synchronous active-low reset clears valids and counter, loads config defaults.
// A stalled result holds its register; the input side keeps moving for rejects.
module tilt_heading_classifier_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  thc_pkg::t_in                       i_data,
    output logic                               o_valid,
    input  logic                               i_ready,
    output thc_pkg::t_out                      o_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [thc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [thc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import thc_pkg::*;

    logic               r_in_valid, n_in_valid;
    t_in                r_in;
    logic               r_out_valid, n_out_valid;
    t_out               r_out;
    logic [COUNT_W-1:0] r_reject_count, n_reject_count;
    t_cfg               r_cfg;
    t_cls               cls;
    logic               out_free, consume, in_ready;

    thc_classify u_classify (
        .i_sample       (r_in),
        .i_cfg          (r_cfg),
        .i_reject_count (r_reject_count),
        .o_cls          (cls)
    );

    always_comb begin
        out_free = !r_out_valid || i_ready;
        consume  = r_in_valid && (cls.reject || out_free);
        in_ready = !r_in_valid || consume;

        n_in_valid  = in_ready ? i_valid : r_in_valid;
        n_out_valid = out_free ? (r_in_valid && !cls.reject) : r_out_valid;

        n_reject_count = r_reject_count;
        if (consume) begin
            if (cls.reject) begin
                if (r_reject_count != COUNT_MAX) begin
                    n_reject_count = r_reject_count + COUNT_W'(1);
                end
            end else begin
                n_reject_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_reject_count <= '0;
        end else begin
            r_in_valid     <= n_in_valid;
            r_out_valid    <= n_out_valid;
            r_reject_count <= n_reject_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && in_ready) begin
            r_in <= i_data;
        end
        if (r_in_valid && !cls.reject && out_free) begin
            r_out <= cls.result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.shake_limit        <= SHAKE_RESET;
            r_cfg.still_limit        <= STILL_RESET;
            r_cfg.moving_min_rejects <= MOVING_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SHAKE_LIMIT: r_cfg.shake_limit <= i_cfg_data[SHAKE_W-1:0];
                CFG_STILL_LIMIT: r_cfg.still_limit <= i_cfg_data[STILL_W-1:0];
                CFG_MOVING_MIN:  r_cfg.moving_min_rejects <= i_cfg_data[MOVE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_ready     = in_ready;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;
    assign o_cfg_ready = 1'b1;

    a_count_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && !cls.reject) |=> (r_reject_count == '0))
        else $error("reject count not cleared after a result");

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |=> (r_reject_count >= $past(r_reject_count) || r_reject_count == '0))
        else $error("reject count went down without a result");

    a_reject_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && cls.reject && i_ready) |=> !o_valid)
        else $error("rejected sample produced a result");

    a_result_graded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.accuracy != '0))
        else $error("result with zero accuracy");

endmodule

@@ verif/tilt_heading_classifier_core_tb.sv @@
`timescale 1ns / 1ps

module tilt_heading_classifier_core_tb;
    import thc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

    localparam int READY_FREE   = 0;
    localparam int READY_COIN   = 1;
    localparam int READY_BURSTY = 2;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    t_in                   i_data = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    t_out                  o_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    tilt_heading_classifier_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor state
    logic [SHAKE_W-1:0] shake_lim = SHAKE_W'(25);
    logic [STILL_W-1:0] still_lim = STILL_W'(14);
    logic [MOVE_W-1:0]  move_min = MOVE_W'(1);
    logic [COUNT_W-1:0] reject_tally = '0;

    t_in  sample_backlog[$];
    t_out owed_headings[$];
    t_out guess;
    t_out want;
    int   errors = 0;
    int   samples_taken = 0;
    int   cfg_beats = 0;
    logic sample_fire = 1'b0;
    bit   hold_sender = 1'b0;

    int burst_left = 1;
    int gap_left = 0;
    int ready_mode = READY_FREE;
    int mode_age = 0;
    int stall_left = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAIL tilt_heading_classifier_core");
        $finish;
    end

    function automatic int pick(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int absval(input int v);
        return v < 0 ? -v : v;
    endfunction

    // raw reading that truncates to the given scaled value
    function automatic logic [15:0] raw_of(input int scaled, input int div);
        int off;
        off = pick(0, div - 1);
        if (scaled > 0) return 16'(scaled * div + off);
        if (scaled < 0) return 16'(scaled * div - off);
        return 16'(pick(0, 1) ? off : -off);
    endfunction

    function automatic logic [15:0] mag_raw();
        if (pick(0, 7) == 0) return 16'($urandom);
        return raw_of(pick(-14, 12), 16);
    endfunction

    function automatic t_in sample_of(input int ax, input int ay, input int az,
                                      input int mx, input int my, input int mz);
        t_in s;
        s.accel_x = 16'(ax);
        s.accel_y = 16'(ay);
        s.accel_z = 16'(az);
        s.mag_x   = 16'(mx);
        s.mag_y   = 16'(my);
        s.mag_z   = 16'(mz);
        return s;
    endfunction

    function automatic t_in good_sample();
        t_in s;
        int  down;
        int  spread;
        down = pick(14, 18);
        spread = pick(0, 1) ? 3 : 9;
        s.accel_x = raw_of(pick(-spread, spread), 256);
        s.accel_y = raw_of(pick(-spread, spread), 256);
        s.accel_z = raw_of(pick(-spread, spread), 256);
        case (pick(0, 2))
            0: s.accel_x = raw_of(down, 256);
            1: s.accel_x = raw_of(-down, 256);
            default: s.accel_y = raw_of(down, 256);
        endcase
        s.mag_x = mag_raw();
        s.mag_y = mag_raw();
        s.mag_z = mag_raw();
        return s;
    endfunction

    function automatic t_in odd_sample();
        t_in s;
        s = good_sample();
        case (pick(0, 4))
            0: s = t_in'({$urandom, $urandom, $urandom});
            1: s.accel_z = raw_of(pick(20, 127) * (pick(0, 1) ? 1 : -1), 256);
            2: begin
                s.accel_x = raw_of(pick(-13, 13), 256);
                s.accel_y = raw_of(pick(-13, 13), 256);
                s.accel_z = raw_of(pick(-13, 13), 256);
            end
            3: begin
                s.accel_x = raw_of(pick(-9, 9), 256);
                s.accel_y = raw_of(-pick(14, 18), 256);
            end
            default: s.accel_x = raw_of((pick(0, 1) ? 13 : 19) * (pick(0, 1) ? 1 : -1), 256);
        endcase
        return s;
    endfunction

    function automatic logic [HEAD_W-1:0] pick_sector(input int m, input int t0, input int t1,
                                                      input int t2, input int t3, input bit zup);
        if (m > t0) return HEAD_W'(270);
        if (m > t1) return zup ? HEAD_W'(225) : HEAD_W'(315);
        if (m > t2) return zup ? HEAD_W'(180) : HEAD_W'(0);
        if (m > t3) return zup ? HEAD_W'(135) : HEAD_W'(45);
        return HEAD_W'(90);
    endfunction

    function automatic bit classify_sample(input t_in s, output t_out r);
        int    ax, ay, az, mx, my, mz;
        int    down_mag;
        t_face face;
        bit    drop;
        r  = '0;
        ax = $signed(s.accel_x) / 256;
        ay = $signed(s.accel_y) / 256;
        az = $signed(s.accel_z) / 256;
        mx = $signed(s.mag_x) / 16;
        my = $signed(s.mag_y) / 16;
        mz = $signed(s.mag_z) / 16;
        if (ax > 13 && ax < 19) begin
            face = FACE_PX;
            down_mag = ax;
        end else if (ax < -13 && ax > -19) begin
            face = FACE_NX;
            down_mag = -ax;
        end else if (ay > 13 && ay < 19) begin
            face = FACE_PY;
            down_mag = ay;
        end else begin
            face = FACE_NONE;
            down_mag = 0;
        end
        drop = (absval(ax) + absval(ay) + absval(az)) > int'(shake_lim)
            || (absval(ax) < int'(still_lim) && absval(ay) < int'(still_lim)
                && absval(az) < int'(still_lim))
            || face == FACE_NONE;
        if (drop) begin
            if (reject_tally != '1) reject_tally = reject_tally + 1'b1;
            return 1'b0;
        end
        case (face)
            FACE_PX: r.heading_deg = pick_sector(-my, 7, 4, -1, -5, mz > 0);
            FACE_NX: r.heading_deg = pick_sector(my, 5, 2, -4, -7, mz > 0);
            default: r.heading_deg = pick_sector(mx, 3, 0, -7, -11, mz > 0);
        endcase
        case (down_mag)
            16:      r.accuracy = ACC_W'(3);
            15, 17:  r.accuracy = ACC_W'(2);
            14, 18:  r.accuracy = ACC_W'(1);
            default: r.accuracy = ACC_W'(0);
        endcase
        r.is_moving = reject_tally > move_min;
        reject_tally = '0;
        return 1'b1;
    endfunction

    task automatic report(input string what, input int got, input int exp_val);
        errors++;
        if (errors <= 50) $display("%0t ns: %s got %0d expected %0d", $time, what, got, exp_val);
    endtask

    // sample driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !sample_fire) begin
            // beat still waiting
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            i_valid <= 1'b0;
        end else if (sample_backlog.size() != 0 && !hold_sender) begin
            i_valid <= 1'b1;
            i_data <= sample_backlog[0];
            if (burst_left <= 1) begin
                burst_left <= pick(1, 40);
                gap_left <= (pick(0, 3) == 0) ? 0 : pick(1, 6);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            i_valid <= 1'b0;
        end
    end

    // result sink stalls
    always @(negedge i_clk) begin
        if (mode_age >= 150) begin
            mode_age <= 0;
            ready_mode <= pick(READY_FREE, READY_BURSTY);
        end else begin
            mode_age <= mode_age + 1;
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else begin
            case (ready_mode)
                READY_FREE: i_ready <= 1'b1;
                READY_COIN: i_ready <= pick(0, 1);
                default: begin
                    if (pick(0, 15) == 0) begin
                        stall_left <= pick(1, 20);
                        i_ready <= 1'b0;
                    end else begin
                        i_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // monitor and predictor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sample_fire <= 1'b0;
            shake_lim = SHAKE_W'(25);
            still_lim = STILL_W'(14);
            move_min = MOVE_W'(1);
            reject_tally = '0;
        end else begin
            sample_fire <= i_valid && o_ready;
            if (o_valid && i_ready) begin
                if (owed_headings.size() == 0) begin
                    report("unexpected result, heading_deg", o_data.heading_deg, 0);
                end else begin
                    want = owed_headings.pop_front();
                    if (o_data.heading_deg !== want.heading_deg)
                        report("heading_deg", o_data.heading_deg, want.heading_deg);
                    if (o_data.accuracy !== want.accuracy)
                        report("accuracy", o_data.accuracy, want.accuracy);
                    if (o_data.is_moving !== want.is_moving)
                        report("is_moving", o_data.is_moving, want.is_moving);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SHAKE_LIMIT: shake_lim = i_cfg_data[SHAKE_W-1:0];
                    CFG_STILL_LIMIT: still_lim = i_cfg_data[STILL_W-1:0];
                    CFG_MOVING_MIN:  move_min = i_cfg_data[MOVE_W-1:0];
                    default: ;
                endcase
                cfg_beats++;
            end
            if (i_valid && o_ready) begin
                if (classify_sample(i_data, guess)) owed_headings.push_back(guess);
                void'(sample_backlog.pop_front());
                samples_taken++;
            end
        end
    end

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        int seen;
        seen = cfg_beats;
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        while (cfg_beats == seen) @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // rejected samples may still be in flight after the last result
    task automatic wait_quiet();
        while (sample_backlog.size() != 0 || i_valid || owed_headings.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic run_batch(input int count, input int odd_pct);
        int mark;
        mark = samples_taken + count / 2;
        repeat (count)
            sample_backlog.push_back((pick(0, 99) < odd_pct) ? odd_sample() : good_sample());
        while (samples_taken < mark) @(negedge i_clk);
        hold_sender = 1'b1;
        while (i_valid || owed_headings.size() != 0) @(negedge i_clk);
        hold_sender = 1'b0;
        wait_quiet();
    endtask

    initial begin
        int n;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: windows, rejects, saturation, moving flag
        sample_backlog.push_back(sample_of(4096, 0, 0, 0, 0, 0));
        sample_backlog.push_back(sample_of(-3839, 768, 0, 0, 96, 16));
        sample_backlog.push_back(sample_of(0, 4863, -512, -128, 0, 16));
        sample_backlog.push_back(sample_of(4864, 0, 0, 0, 0, 0));
        sample_backlog.push_back(sample_of(-3583, 0, 512, 0, 0, 0));
        sample_backlog.push_back(sample_of(0, -4096, 0, 0, 0, 0));
        sample_backlog.push_back(sample_of(0, 0, 0, 32767, -32768, 32767));
        sample_backlog.push_back(sample_of(4096, 2560, 0, 0, 0, 0));
        sample_backlog.push_back(sample_of(3840, 0, 0, 0, -160, -1));
        sample_backlog.push_back(sample_of(0, 0, 0, 0, 0, 0));
        sample_backlog.push_back(sample_of(4352, 0, -256, 64, 40, 80));
        sample_backlog.push_back(sample_of(0, 0, 0, 0, 0, 0));
        sample_backlog.push_back(sample_of(0, 0, 0, 0, 0, 0));
        sample_backlog.push_back(sample_of(-4096, 0, 0, 0, -112, -32));
        wait_quiet();

        // wide open limits: face priority and field extremes
        set_reg(CFG_SHAKE_LIMIT, 9'd511);
        set_reg(CFG_STILL_LIMIT, 9'd0);
        set_reg(CFG_MOVING_MIN, 9'd0);
        sample_backlog.push_back(sample_of(4096, 4096, 0, 0, 48, 0));
        sample_backlog.push_back(sample_of(-4096, 3840, 0, 0, -48, 32));
        sample_backlog.push_back(sample_of(32767, 32767, 32767, 32767, 32767, 32767));
        sample_backlog.push_back(sample_of(-32768, -32768, -32768, -32768, -32768, -32768));
        sample_backlog.push_back(sample_of(4096, 0, 0, 32767, -32768, 32767));
        sample_backlog.push_back(sample_of(0, 4096, 0, -32768, 0, -32768));
        sample_backlog.push_back(sample_of(-4863, 0, 0, 0, -15, -15));
        wait_quiet();

        set_reg(CFG_SHAKE_LIMIT, 9'd25);
        set_reg(CFG_STILL_LIMIT, 9'h10E);
        set_reg(CFG_MOVING_MIN, 9'h1FD);
        run_batch(350, 30);

        set_reg(CFG_SHAKE_LIMIT, 9'd511);
        set_reg(CFG_STILL_LIMIT, 9'd0);
        set_reg(CFG_MOVING_MIN, 9'd0);
        run_batch(300, 40);

        set_reg(CFG_SHAKE_LIMIT, 9'd0);
        set_reg(CFG_STILL_LIMIT, 9'd255);
        set_reg(CFG_MOVING_MIN, 9'd2);
        run_batch(60, 20);

        set_reg(CFG_NO_REG, 9'(pick(0, 511)));
        set_reg(CFG_SHAKE_LIMIT, 9'd40);
        set_reg(CFG_STILL_LIMIT, 9'd10);
        set_reg(CFG_MOVING_MIN, 9'd3);
        run_batch(300, 35);

        repeat (3) begin
            set_reg(CFG_NO_REG, 9'(pick(0, 511)));
            set_reg(CFG_SHAKE_LIMIT, 9'(pick(14, 80)));
            set_reg(CFG_STILL_LIMIT, {1'(pick(0, 1)), 8'(pick(0, 20))});
            set_reg(CFG_MOVING_MIN, {7'(pick(0, 127)), 2'(pick(0, 3))});
            run_batch(220, 35);
        end

        while (sample_backlog.size() != 0 || i_valid) @(negedge i_clk);
        n = 0;
        while (owed_headings.size() != 0 && n < 20000) begin
            @(negedge i_clk);
            n++;
        end
        repeat (10) @(negedge i_clk);
        if (owed_headings.size() != 0) report("results missing", owed_headings.size(), 0);
        if (errors == 0) begin
            $display("PASS tilt_heading_classifier_core");
        end else begin
            $display("FAIL tilt_heading_classifier_core");
        end
        $finish;
    end

endmodule
